// File: hdl/lzmt_pkg.sv
// ----------------------------------------------------------------------------
// lzmt_pkg
// Shared constants, codes and control types of the LZSS match tokeniser.
// ----------------------------------------------------------------------------
package lzmt_pkg;

	localparam int WINDOW       = 1024;
	localparam int BUFFER_DEPTH = 2048;
	localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
	// positions are kept modulo twice the ring depth
	localparam int PTR_W        = ADDR_W + 1;
	localparam int OFF_W        = $clog2(WINDOW + 1);
	localparam int MIN_MATCH    = 2;

	localparam int STATUS_W = 3;
	localparam int LIT_W    = 8;
	localparam int DIST_W   = 10;
	localparam int LEN_W    = 11;
	localparam int TDATA_W  = 32;

	typedef enum logic [STATUS_W-1:0] {
		ST_PUSH_OK   = 3'd0,
		ST_TOKEN     = 3'd1,
		ST_NEED_DATA = 3'd2,
		ST_FINISHED  = 3'd3,
		ST_REJECTED  = 3'd4
	} status_t;

	typedef enum logic {
		ACT_PUSH  = 1'b0,
		ACT_TOKEN = 1'b1
	} action_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_LIT_RD,
		S_LIT_CAP,
		S_CMP_RD,
		S_CMP,
		S_COMMIT,
		S_OUT
	} ctl_state_t;

	typedef struct packed {
		logic    load_in;
		logic    push_wr;
		logic    set_code;
		status_t code;
		logic    search_init;
		logic    lit_cap;
		logic    k_inc;
		logic    cand_end;
		logic    commit;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic is_push;
		logic reject;
		logic need_data;
		logic finished;
		logic co_zero;
		logic k_continue;
		logic last_cand;
		logic out_free;
	} dp_status_t;

endpackage

// File: hdl/lzmt_ctrl.sv
// ----------------------------------------------------------------------------
// lzmt_ctrl
// Sequencer for push handling, the candidate-by-candidate search and output.
// ----------------------------------------------------------------------------
module lzmt_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_fire,
	input  lzmt_pkg::dp_status_t  st,
	output logic                  idle,
	output lzmt_pkg::dp_cmd_t     cmd
);

	lzmt_pkg::ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzmt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lzmt_pkg::S_IDLE: begin
				if (in_fire) state_d = lzmt_pkg::S_EVAL;
			end
			lzmt_pkg::S_EVAL: begin
				if (st.is_push || st.need_data || st.finished) state_d = lzmt_pkg::S_OUT;
				else state_d = lzmt_pkg::S_LIT_RD;
			end
			lzmt_pkg::S_LIT_RD:  state_d = lzmt_pkg::S_LIT_CAP;
			lzmt_pkg::S_LIT_CAP: begin
				state_d = st.co_zero ? lzmt_pkg::S_COMMIT : lzmt_pkg::S_CMP_RD;
			end
			lzmt_pkg::S_CMP_RD: state_d = lzmt_pkg::S_CMP;
			lzmt_pkg::S_CMP: begin
				if (st.k_continue) state_d = lzmt_pkg::S_CMP_RD;
				else if (st.last_cand) state_d = lzmt_pkg::S_COMMIT;
				else state_d = lzmt_pkg::S_CMP_RD;
			end
			lzmt_pkg::S_COMMIT: state_d = lzmt_pkg::S_OUT;
			lzmt_pkg::S_OUT: begin
				if (st.out_free) state_d = lzmt_pkg::S_IDLE;
			end
			default: state_d = lzmt_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.code = lzmt_pkg::ST_PUSH_OK;
		idle     = 1'b0;
		unique case (state_q)
			lzmt_pkg::S_IDLE: begin
				idle        = 1'b1;
				cmd.load_in = in_fire;
			end
			lzmt_pkg::S_EVAL: begin
				cmd.set_code = st.is_push || st.need_data || st.finished;
				if (st.is_push) begin
					if (st.reject) begin
						cmd.code = lzmt_pkg::ST_REJECTED;
					end else begin
						cmd.push_wr = 1'b1;
						cmd.code    = lzmt_pkg::ST_PUSH_OK;
					end
				end else if (st.need_data) begin
					cmd.code = lzmt_pkg::ST_NEED_DATA;
				end else if (st.finished) begin
					cmd.code = lzmt_pkg::ST_FINISHED;
				end else begin
					cmd.search_init = 1'b1;
				end
			end
			lzmt_pkg::S_LIT_RD: ;
			lzmt_pkg::S_LIT_CAP: cmd.lit_cap = 1'b1;
			lzmt_pkg::S_CMP_RD: ;
			lzmt_pkg::S_CMP: begin
				if (st.k_continue) cmd.k_inc = 1'b1;
				else cmd.cand_end = 1'b1;
			end
			lzmt_pkg::S_COMMIT: begin
				cmd.commit   = 1'b1;
				cmd.set_code = 1'b1;
				cmd.code     = lzmt_pkg::ST_TOKEN;
			end
			lzmt_pkg::S_OUT: cmd.out_load = st.out_free;
			default: ;
		endcase
	end

endmodule

// File: hdl/lzmt_dp.sv
// ----------------------------------------------------------------------------
// lzmt_dp
// History ring, position counters, match search registers and output stage.
// ----------------------------------------------------------------------------
module lzmt_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lzmt_pkg::dp_cmd_t                 cmd,
	output lzmt_pkg::dp_status_t              st,
	input  logic                              in_action,
	input  logic [lzmt_pkg::LIT_W-1:0]        in_byte,
	input  logic                              in_last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [lzmt_pkg::TDATA_W-1:0]      out_data,
	output logic [lzmt_pkg::STATUS_W-1:0]     out_status
);

	localparam int PW = lzmt_pkg::PTR_W;
	localparam int OW = lzmt_pkg::OFF_W;
	localparam int AW = lzmt_pkg::ADDR_W;

	logic [lzmt_pkg::LIT_W-1:0] mem [lzmt_pkg::BUFFER_DEPTH];
	logic [lzmt_pkg::LIT_W-1:0] rd_a_q, rd_b_q;

	logic [PW-1:0] ws_q, cur_q, rcv_q;
	logic          closed_q;
	logic          act_q, last_q;
	logic [lzmt_pkg::LIT_W-1:0] byte_q, lit_q;
	logic [OW-1:0] eo_q, co_q, c_q, k_q, best_len_q, best_dist_q;
	lzmt_pkg::status_t code_q;

	logic          out_valid_q;
	logic [lzmt_pkg::TDATA_W-1:0]  out_data_q;
	logic [lzmt_pkg::STATUS_W-1:0] out_status_q;

	logic [PW-1:0] avail, co_full, cur_new, hist_new;
	logic [OW-1:0] eo_c, k_fin, floor_len;
	logic [OW:0]   k_next_end;
	logic          eq;
	logic [AW-1:0] addr_a, addr_b;
	logic [lzmt_pkg::TDATA_W-1:0]  tok_word;

	assign avail   = rcv_q - ws_q;
	assign co_full = cur_q - ws_q;
	assign eo_c    = (32'(avail) >= 32'(lzmt_pkg::WINDOW)) ? OW'(lzmt_pkg::WINDOW)
	                                                       : OW'(avail);
	assign eq         = (rd_a_q == rd_b_q);
	assign k_next_end = {1'b0, co_q} + {1'b0, k_q} + (OW+1)'(1);
	assign k_fin      = eq ? k_q + OW'(1) : k_q;
	assign floor_len  = (32'(best_len_q) > 32'(lzmt_pkg::MIN_MATCH))
	                    ? best_len_q : OW'(lzmt_pkg::MIN_MATCH);
	assign cur_new    = cur_q + PW'(best_len_q);
	// history length after the commit, wrapped at the pointer width
	assign hist_new   = cur_new - ws_q;

	assign addr_a = AW'(ws_q + PW'(c_q) + PW'(k_q));
	assign addr_b = AW'(ws_q + PW'(co_q) + PW'(k_q));

	always_comb begin
		st.is_push    = (act_q == lzmt_pkg::ACT_PUSH);
		st.reject     = closed_q || (32'(avail) >= 32'(lzmt_pkg::BUFFER_DEPTH));
		st.need_data  = !closed_q && (32'(avail) < 32'(lzmt_pkg::WINDOW));
		st.finished   = 32'(co_full) >= 32'(eo_c);
		st.co_zero    = (co_q == '0);
		st.k_continue = eq && (k_next_end < {1'b0, eo_q});
		st.last_cand  = (c_q + OW'(1) == co_q);
		st.out_free   = !out_valid_q || out_ready;
	end

	always_comb begin
		tok_word = '0;
		if (code_q == lzmt_pkg::ST_TOKEN) begin
			if (best_dist_q != '0) begin
				tok_word[0]     = 1'b1;
				tok_word[18:9]  = lzmt_pkg::DIST_W'(best_dist_q);
				tok_word[29:19] = lzmt_pkg::LEN_W'(best_len_q);
			end else begin
				tok_word[8:1]   = lit_q;
				tok_word[29:19] = lzmt_pkg::LEN_W'(1);
			end
		end
	end

	// ring write on push, both read ports registered
	always_ff @(posedge clk) begin
		if (cmd.push_wr) mem[AW'(rcv_q)] <= byte_q;
		rd_a_q <= mem[addr_a];
		rd_b_q <= mem[addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q        <= '0;
			cur_q       <= '0;
			rcv_q       <= '0;
			closed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.push_wr) begin
				rcv_q <= rcv_q + PW'(1);
				if (last_q) closed_q <= 1'b1;
			end
			if (cmd.commit) begin
				cur_q <= cur_new;
				if (32'(hist_new) > 32'(lzmt_pkg::WINDOW / 2))
					ws_q <= ws_q + PW'(best_len_q);
			end
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			act_q  <= in_action;
			byte_q <= in_byte;
			last_q <= in_last;
		end
		if (cmd.set_code) code_q <= cmd.code;
		if (cmd.search_init) begin
			eo_q        <= eo_c;
			co_q        <= OW'(co_full);
			c_q         <= '0;
			k_q         <= '0;
			best_len_q  <= OW'(1);
			best_dist_q <= '0;
		end
		if (cmd.lit_cap) lit_q <= rd_b_q;
		if (cmd.k_inc) k_q <= k_q + OW'(1);
		if (cmd.cand_end) begin
			if (k_fin > floor_len) begin
				best_len_q  <= k_fin;
				best_dist_q <= co_q - c_q;
			end
			c_q <= c_q + OW'(1);
			k_q <= '0;
		end
		if (cmd.out_load) begin
			out_status_q <= code_q;
			out_data_q   <= tok_word;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;
	assign out_status = out_status_q;

endmodule

// File: hdl/lzss_match_tokenizer_top.sv
// ----------------------------------------------------------------------------
// lzss_match_tokenizer_top
// LZSS tokeniser: byte push into a history ring, brute-force token search.
// ----------------------------------------------------------------------------
// A push (tuser 0) stores one byte, or is refused when the stream is
// closed or the ring is full. A token request (tuser 1) answers need-data
// or finished when it cannot search; otherwise it scans every history
// position from the window start up to the one before the current
// position. Each byte compared takes a registered dual read of the history
// ring, then a compare. The history never exceeds WINDOW / 2 positions.
// One transaction is processed at a time.
module lzss_match_tokenizer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_tuser,   // [0] action
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [0] is_match, [8:1] literal,
	                               // [18:9] match_distance, [29:19] match_length
	output logic [2:0]  m_tuser    // [2:0] status
);

	lzmt_pkg::dp_cmd_t    cmd;
	lzmt_pkg::dp_status_t st;
	logic                 idle;

	assign s_tready = idle;

	lzmt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (s_tvalid && idle),
		.st      (st),
		.idle    (idle),
		.cmd     (cmd)
	);

	lzmt_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.in_action  (s_tuser[0]),
		.in_byte    (s_tdata),
		.in_last    (s_tlast),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata),
		.out_status (m_tuser)
	);

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the LZSS match tokeniser: need-data polls on an open
// stream of structured bytes, the close, refused pushes and the drain to finish.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned IDLE_LIMIT = 5_000_000;
	localparam int unsigned TAIL_CYCLES = 50;

	typedef struct {
		lzmt_pkg::action_t act;
		logic [7:0]        b;
		logic              last;
	} byte_req_t;

	typedef struct {
		lzmt_pkg::status_t              status;
		logic                           is_match;
		logic [lzmt_pkg::LIT_W-1:0]     lit;
		logic [lzmt_pkg::DIST_W-1:0]    mdist;
		logic [lzmt_pkg::LEN_W-1:0]     len;
	} token_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;

	lzss_match_tokenizer_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// own copy of the tokeniser state
	logic [7:0]  hist [lzmt_pkg::BUFFER_DEPTH];
	int unsigned win_start = 0, cur_pos = 0, rx_cnt = 0;
	bit          closed = 0, fin_seen = 0;

	byte_req_t   pending_q[$];
	token_t      tokens_q[$];
	byte_req_t   cur_req;
	bit          taken = 0;
	int unsigned n_queued = 0, n_accepted = 0;
	int unsigned errors = 0, idle_cycles = 0;
	int unsigned n_match = 0, n_lit = 0, n_rej = 0, n_need = 0, n_fin = 0;

	// stream content generator state
	logic [7:0]  gen[$];
	int unsigned copy_left = 0, copy_dist = 0;

	function automatic token_t tokenise(byte_req_t it);
		token_t r;
		int unsigned avail, co, eo, blen, bdist, c, k, fl;
		r.status = lzmt_pkg::ST_PUSH_OK;
		r.is_match = 1'b0;
		r.lit = '0;
		r.mdist = '0;
		r.len = '0;
		if (it.act == lzmt_pkg::ACT_PUSH) begin
			if (closed || rx_cnt - win_start >= lzmt_pkg::BUFFER_DEPTH) begin
				r.status = lzmt_pkg::ST_REJECTED;
			end else begin
				hist[rx_cnt % lzmt_pkg::BUFFER_DEPTH] = it.b;
				rx_cnt++;
				if (it.last)
					closed = 1;
			end
			return r;
		end
		avail = rx_cnt - win_start;
		co = cur_pos - win_start;
		if (avail >= lzmt_pkg::WINDOW)
			eo = lzmt_pkg::WINDOW;
		else if (closed)
			eo = avail;
		else begin
			r.status = lzmt_pkg::ST_NEED_DATA;
			return r;
		end
		if (co >= eo) begin
			r.status = lzmt_pkg::ST_FINISHED;
			return r;
		end
		blen = 1;
		bdist = 0;
		// earliest candidate wins on equal length; overlap into lookahead allowed
		for (c = 0; c < co; c++) begin
			k = 0;
			while (co + k < eo && hist[(win_start + c + k) % lzmt_pkg::BUFFER_DEPTH] ==
					hist[(win_start + co + k) % lzmt_pkg::BUFFER_DEPTH])
				k++;
			fl = (blen > lzmt_pkg::MIN_MATCH) ? blen : lzmt_pkg::MIN_MATCH;
			if (k > fl) begin
				blen = k;
				bdist = co - c;
			end
		end
		r.status = lzmt_pkg::ST_TOKEN;
		if (bdist > 0) begin
			r.is_match = 1'b1;
			r.mdist = bdist[lzmt_pkg::DIST_W-1:0];
			r.len = blen[lzmt_pkg::LEN_W-1:0];
		end else begin
			r.lit = hist[cur_pos % lzmt_pkg::BUFFER_DEPTH];
			r.len = lzmt_pkg::LEN_W'(1);
		end
		cur_pos += blen;
		if (cur_pos - win_start > lzmt_pkg::WINDOW / 2)
			win_start += blen;
		return r;
	endfunction

	task automatic add_req(lzmt_pkg::action_t act, logic [7:0] b, logic last);
		byte_req_t it;
		it.act = act;
		it.b = b;
		it.last = last;
		pending_q.push_back(it);
		n_queued++;
	endtask

	// mostly a small alphabet with copies of earlier runs, so matches are common
	function automatic logic [7:0] next_byte();
		logic [7:0] b;
		if (copy_left == 0 && gen.size() > 8 && $urandom_range(0, 9) < 4) begin
			copy_dist = $urandom_range(1, (gen.size() < 300) ? gen.size() : 300);
			copy_left = $urandom_range(3, 24);
		end
		if (copy_left > 0) begin
			b = gen[gen.size() - copy_dist];
			copy_left--;
		end else if ($urandom_range(0, 9) == 0)
			b = 8'($urandom_range(0, 255));
		else
			b = 8'(8'h40 + $urandom_range(0, 3));
		gen.push_back(b);
		return b;
	endfunction

	task automatic add_token();
		add_req(lzmt_pkg::ACT_TOKEN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	task automatic drain();
		wait (n_accepted == n_queued && tokens_q.size() == 0);
	endtask

	// stimulus
	initial begin
		int i;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// directed: need-data on empty stream, byte extremes
		add_token();
		add_req(lzmt_pkg::ACT_PUSH, 8'h00, 1'b0);
		add_req(lzmt_pkg::ACT_PUSH, 8'hFF, 1'b0);
		add_req(lzmt_pkg::ACT_PUSH, 8'hA5, 1'b0);
		add_req(lzmt_pkg::ACT_PUSH, 8'h5A, 1'b0);
		add_token();
		gen.push_back(8'h00);
		gen.push_back(8'hFF);
		gen.push_back(8'hA5);
		gen.push_back(8'h5A);

		// open stream shorter than the window: polls answer need-data
		for (i = 0; i < 300; i++) begin
			add_req(lzmt_pkg::ACT_PUSH, next_byte(), 1'b0);
			if (i % 10 == 9)
				add_token();
		end
		drain();
		repeat (TAIL_CYCLES) @(negedge clk);

		// close the stream, then pushes after close are refused
		add_req(lzmt_pkg::ACT_PUSH, next_byte(), 1'b1);
		add_req(lzmt_pkg::ACT_PUSH, 8'hFF, 1'b1);
		add_req(lzmt_pkg::ACT_PUSH, 8'h00, 1'b0);

		// drain to the end of the stream
		while (!fin_seen) begin
			for (i = 0; i < 20; i++)
				add_token();
			drain();
		end
		add_token();
		add_token();
		drain();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Covered %0d literals, %0d matches, %0d refused pushes,",
			n_lit, n_match, n_rej);
		$display("%0d need-data and %0d finished answers over %0d transactions.",
			n_need, n_fin, n_accepted);
		if (errors == 0 && tokens_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// driver: bursts with random gaps
	int unsigned burst_left = 4, gap_left = 0;
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || taken)) begin
			taken = 0;
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_q.size() > 0) begin
				cur_req = pending_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= cur_req.act;
				s_tdata <= cur_req.b;
				s_tlast <= cur_req.last;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else
				s_tvalid <= 1'b0;
		end
	end

	// receiver stall pattern: always ready, coin toss, or long holds
	int unsigned rx_mode = 0, rx_left = 0;
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_left = $urandom_range(5, 60);
		end
		rx_left--;
		case (rx_mode)
		0: m_tready <= 1'b1;
		1: m_tready <= 1'($urandom_range(0, 1));
		default: m_tready <= (rx_left % 8 == 0);
		endcase
	end

	// acceptance, prediction and checking
	always @(posedge clk) begin
		token_t e, a;
		bit accepted;
		accepted = 0;
		if (s_tvalid && s_tready && !taken) begin
			e = tokenise(cur_req);
			tokens_q.push_back(e);
			taken = 1;
			n_accepted++;
			accepted = 1;
			case (e.status)
			lzmt_pkg::ST_TOKEN: if (e.is_match) n_match++; else n_lit++;
			lzmt_pkg::ST_REJECTED: n_rej++;
			lzmt_pkg::ST_NEED_DATA: n_need++;
			lzmt_pkg::ST_FINISHED: begin
				n_fin++;
				fin_seen = 1;
			end
			default: ;
			endcase
		end
		if (m_tvalid && m_tready) begin
			accepted = 1;
			a.status = lzmt_pkg::status_t'(m_tuser);
			a.is_match = m_tdata[0];
			a.lit = m_tdata[8:1];
			a.mdist = m_tdata[18:9];
			a.len = m_tdata[29:19];
			if (tokens_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("Unexpected result: status %0d", m_tuser);
			end else begin
				e = tokens_q.pop_front();
				if (a.status !== e.status || a.is_match !== e.is_match ||
						a.lit !== e.lit || a.mdist !== e.mdist || a.len !== e.len) begin
					errors++;
					if (errors <= 10) begin
						$display("Mismatch: exp st=%0d m=%0d lit=%02h d=%0d l=%0d,",
							e.status, e.is_match, e.lit, e.mdist, e.len);
						$display("          got st=%0d m=%0d lit=%02h d=%0d l=%0d",
							m_tuser, a.is_match, a.lit, a.mdist, a.len);
					end
				end
			end
		end
		// watchdog on cycles with no transaction on either side
		if (accepted)
			idle_cycles = 0;
		else if (arst_n) begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout with %0d results outstanding", tokens_q.size());
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

endmodule
